>>> rtl/sbpr_pkg.sv
// shared types and constants of the sensor bus poll responder
package sbpr_pkg;

	localparam int NUM_SLOTS   = 16;
	localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int REPLY_BYTES = 3;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;

	localparam logic [15:0] NO_VALUE   = 16'h8000;
	localparam logic [3:0]  BYTE_BITS  = 4'd8;
	localparam logic [3:0]  STOP_BIT   = 4'd9;
	localparam logic [15:0] CNT_MAX    = 16'hffff;

	localparam logic [15:0] RST_BIT_TICKS   = 16'd26;
	localparam logic [15:0] RST_REPLY_GAP   = 16'd1600;
	localparam logic [15:0] RST_POST_TX_GAP = 16'd2000;
	localparam logic [15:0] RST_BUSY_GAP    = 16'd4000;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RECEIVE  = 3'd1,
		PH_WAITING  = 3'd2,
		PH_PENDING  = 3'd3,
		PH_TRANSMIT = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_DECLARE = 2'd1,
		CMD_STORE   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_INACTIVE  = 2'd0,
		ST_AVAILABLE = 2'd1,
		ST_SENT      = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIT_TICKS   = 2'd0,
		REG_REPLY_GAP   = 2'd1,
		REG_POST_TX_GAP = 2'd2,
		REG_BUSY_GAP    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         command;
		logic               line_in;
		logic [3:0]         slot;
		logic [3:0]         unit;
		logic signed [14:0] value;
		logic               alarm;
	} item_t;

	typedef struct packed {
		logic   line_drive;
		logic   line_level;
		phase_t phase;
		logic   poll_answered;
	} result_t;

	// slot table write request from the host side
	typedef struct packed {
		logic        declare;
		logic        store;
		logic [3:0]  slot;
		logic [3:0]  unit;
		logic [15:0] data;
	} slot_upd_t;

	// slot table lookup result for a polled address
	typedef struct packed {
		logic [7:0]  header;
		logic [15:0] data;
		status_t     status;
	} slot_rd_t;

endpackage

>>> rtl/sbpr_if.sv
// valid/ready channel interfaces for items and results
interface sbpr_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic               line_in;
	logic [3:0]         slot;
	logic [3:0]         unit;
	logic signed [14:0] value;
	logic               alarm;

	modport source(output valid, command, line_in, slot, unit, value, alarm, input ready);
	modport sink(input valid, command, line_in, slot, unit, value, alarm, output ready);
endinterface

interface sbpr_out_if;
	logic       valid;
	logic       ready;
	logic       line_drive;
	logic       line_level;
	logic [2:0] phase;
	logic       poll_answered;

	modport source(output valid, line_drive, line_level, phase, poll_answered, input ready);
	modport sink(input valid, line_drive, line_level, phase, poll_answered, output ready);
endinterface

>>> rtl/sbpr_slot_table.sv
// per-slot header, data and status registers with update and sent marking
module sbpr_slot_table
	import sbpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  slot_upd_t         upd,
	input  logic              mark_en,
	input  logic [SLOT_W-1:0] mark_addr,
	input  logic [SLOT_W-1:0] rd_addr,
	output slot_rd_t          rd
);

	logic [7:0]  header_q [NUM_SLOTS];
	logic [15:0] data_q   [NUM_SLOTS];
	status_t     status_q [NUM_SLOTS];
	logic        upd_in_range;
	logic [SLOT_W-1:0] upd_idx;

	assign upd_in_range = ({1'b0, upd.slot} < 5'(NUM_SLOTS));
	assign upd_idx      = upd.slot[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				header_q[i] <= 8'(i);
				data_q[i]   <= NO_VALUE;
				status_q[i] <= ST_INACTIVE;
			end
		end else begin
			if (upd.declare && upd_in_range) begin
				header_q[upd_idx] <= {upd.slot, upd.unit};
				data_q[upd_idx]   <= NO_VALUE;
				status_q[upd_idx] <= ST_AVAILABLE;
			end else if (upd.store && upd_in_range) begin
				data_q[upd_idx]   <= upd.data;
				status_q[upd_idx] <= ST_AVAILABLE;
			end
			if (mark_en) begin
				status_q[mark_addr] <= ST_SENT;
			end
		end
	end

	assign rd.header = header_q[rd_addr];
	assign rd.data   = data_q[rd_addr];
	assign rd.status = status_q[rd_addr];

endmodule

>>> rtl/sensor_bus_poll_responder.sv
// top level: single-wire uart sensor bus slave with slot table
//
// item_in carries one item per transaction: a timebase tick with the sampled
// line level, or a slot declare/store from the host. result_out returns exactly
// one result per item: line drive enable, driven level, bus phase and a pulse
// when a valid poll loads a reply.
// cfg_we/cfg_index/cfg_data write the four timing registers (bit period, reply
// gap, post-transmit gap, busy gap); write only while no item is in flight.
// the item passes the input register, then the result register. throughput:
// one item per cycle while the result is taken; the whole tick update is one
// pass of logic between those two registers.
// a stalled receiver holds the result register; the input register still takes
// one more item, then item_in.ready drops until the result is taken.
// reset: idle phase, counters cleared, timing registers at their defaults,
// every slot inactive with header equal to its index and no value stored.
module sensor_bus_poll_responder
	import sbpr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	sbpr_in_if.sink              item_in,
	sbpr_out_if.source           result_out
);

	// timing registers
	logic [15:0] bit_ticks_q, reply_gap_q, post_tx_gap_q, busy_gap_q;

	// input stage and result stage
	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	logic    out_free, proc, in_acc;

	// bus engine state
	phase_t      phase_q, phase_d;
	logic [15:0] count_q, count_d;
	logic [3:0]  bit_idx_q, bit_idx_d;
	logic [7:0]  shift_q, shift_d;
	logic [1:0]  rbyte_q, rbyte_d;
	logic [7:0]  reply_q [REPLY_BYTES];
	logic [7:0]  reply_d [REPLY_BYTES];
	logic        prev_line_q, prev_line_d;
	logic        drive_q, drive_d;
	logic        answered_d;

	// helpers
	logic        expired;
	logic [15:0] count_dec;
	logic [16:0] start_sum;
	logic [15:0] start_cnt;
	logic [1:0]  rbyte_inc;
	logic        addr_ok;
	logic        is_tick;

	// slot table
	slot_upd_t upd;
	slot_rd_t  slot_rd;
	logic      mark_en;

	// ---------------------------------------------------------------
	// configuration writes
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q   <= RST_BIT_TICKS;
			reply_gap_q   <= RST_REPLY_GAP;
			post_tx_gap_q <= RST_POST_TX_GAP;
			busy_gap_q    <= RST_BUSY_GAP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BIT_TICKS:   bit_ticks_q   <= cfg_data;
				REG_REPLY_GAP:   reply_gap_q   <= cfg_data;
				REG_POST_TX_GAP: post_tx_gap_q <= cfg_data;
				REG_BUSY_GAP:    busy_gap_q    <= cfg_data;
				default:         ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// handshakes: the input register refills whenever its item moves on
	// ---------------------------------------------------------------
	assign out_free      = !out_valid_q || result_out.ready;
	assign proc          = valid_s1 && out_free;
	assign item_in.ready = !valid_s1 || out_free;
	assign in_acc        = item_in.valid && item_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.command <= item_in.command;
			item_s1.line_in <= item_in.line_in;
			item_s1.slot    <= item_in.slot;
			item_s1.unit    <= item_in.unit;
			item_s1.value   <= item_in.value;
			item_s1.alarm   <= item_in.alarm;
		end
	end

	// ---------------------------------------------------------------
	// slot table: host updates and sent marking never share a transaction
	// ---------------------------------------------------------------
	assign upd.declare = proc && (item_s1.command == CMD_DECLARE);
	assign upd.store   = proc && (item_s1.command == CMD_STORE);
	assign upd.slot    = item_s1.slot;
	assign upd.unit    = item_s1.unit;
	assign upd.data    = {item_s1.value, item_s1.alarm};

	sbpr_slot_table u_slot_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.mark_en  (mark_en),
		.mark_addr(shift_q[SLOT_W-1:0]),
		.rd_addr  (shift_q[SLOT_W-1:0]),
		.rd       (slot_rd)
	);

	// ---------------------------------------------------------------
	// bus engine state register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			count_q     <= '0;
			bit_idx_q   <= '0;
			shift_q     <= '0;
			rbyte_q     <= '0;
			prev_line_q <= 1'b1;
			drive_q     <= 1'b0;
			for (int i = 0; i < REPLY_BYTES; i++) begin
				reply_q[i] <= '0;
			end
		end else if (proc) begin
			phase_q     <= phase_d;
			count_q     <= count_d;
			bit_idx_q   <= bit_idx_d;
			shift_q     <= shift_d;
			rbyte_q     <= rbyte_d;
			prev_line_q <= prev_line_d;
			drive_q     <= drive_d;
			for (int i = 0; i < REPLY_BYTES; i++) begin
				reply_q[i] <= reply_d[i];
			end
		end
	end

	// countdown: a loaded zero expires on the next tick like a one
	assign expired   = (count_q <= 16'd1);
	assign count_dec = expired ? 16'd0 : count_q - 16'd1;

	// first data sample sits 1.5 bit periods after the start edge
	assign start_sum = {1'b0, bit_ticks_q} + {2'b00, bit_ticks_q[15:1]};
	assign start_cnt = start_sum[16] ? CNT_MAX : start_sum[15:0];

	assign rbyte_inc = rbyte_q + 2'd1;
	assign addr_ok   = (shift_q < 8'(NUM_SLOTS));
	assign is_tick   = (item_s1.command == CMD_TICK);

	// ---------------------------------------------------------------
	// bus engine next state
	// ---------------------------------------------------------------
	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		bit_idx_d   = bit_idx_q;
		shift_d     = shift_q;
		rbyte_d     = rbyte_q;
		prev_line_d = prev_line_q;
		drive_d     = drive_q;
		answered_d  = 1'b0;
		mark_en     = 1'b0;
		for (int i = 0; i < REPLY_BYTES; i++) begin
			reply_d[i] = reply_q[i];
		end

		if (is_tick) begin
			prev_line_d = item_s1.line_in;
			case (phase_q)
				PH_IDLE: begin
					// falling edge starts reception
					if (prev_line_q && !item_s1.line_in) begin
						count_d   = start_cnt;
						bit_idx_d = '0;
						shift_d   = '0;
						phase_d   = PH_RECEIVE;
					end
				end
				PH_RECEIVE: begin
					count_d = count_dec;
					if (expired) begin
						if (bit_idx_q < BYTE_BITS) begin
							// lsb first: new bit enters at the top
							shift_d   = {item_s1.line_in, shift_q[7:1]};
							bit_idx_d = bit_idx_q + 4'd1;
							count_d   = bit_ticks_q;
						end else if (!addr_ok || slot_rd.status != ST_AVAILABLE) begin
							phase_d = PH_WAITING;
							count_d = busy_gap_q;
						end else begin
							reply_d[0] = slot_rd.header;
							reply_d[1] = slot_rd.data[7:0];
							reply_d[2] = slot_rd.data[15:8];
							mark_en    = proc && (slot_rd.data != NO_VALUE);
							phase_d    = PH_PENDING;
							count_d    = reply_gap_q;
							answered_d = 1'b1;
						end
					end
				end
				PH_WAITING: begin
					count_d = count_dec;
					if (expired) begin
						phase_d = PH_IDLE;
					end
				end
				PH_PENDING: begin
					count_d = count_dec;
					if (expired) begin
						// start bit of the header byte
						drive_d   = 1'b0;
						bit_idx_d = '0;
						shift_d   = reply_q[0];
						rbyte_d   = '0;
						count_d   = bit_ticks_q;
						phase_d   = PH_TRANSMIT;
					end
				end
				PH_TRANSMIT: begin
					count_d = count_dec;
					if (expired) begin
						if (bit_idx_q < BYTE_BITS) begin
							drive_d   = shift_q[0];
							shift_d   = {1'b0, shift_q[7:1]};
							bit_idx_d = bit_idx_q + 4'd1;
							count_d   = bit_ticks_q;
						end else if (bit_idx_q == BYTE_BITS) begin
							// stop bit
							drive_d   = 1'b1;
							bit_idx_d = STOP_BIT;
							count_d   = bit_ticks_q;
						end else begin
							rbyte_d = rbyte_inc;
							if (rbyte_inc < 2'(REPLY_BYTES)) begin
								shift_d   = reply_q[rbyte_inc];
								drive_d   = 1'b0;
								bit_idx_d = '0;
								count_d   = bit_ticks_q;
							end else begin
								drive_d = 1'b0;
								phase_d = PH_WAITING;
								count_d = post_tx_gap_q;
							end
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// result register: every item yields one result
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_q.line_drive    <= (phase_d == PH_TRANSMIT);
			res_q.line_level    <= (phase_d == PH_TRANSMIT) && drive_d;
			res_q.phase         <= phase_d;
			res_q.poll_answered <= answered_d;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.line_drive    = res_q.line_drive;
	assign result_out.line_level    = res_q.line_level;
	assign result_out.phase         = res_q.phase;
	assign result_out.poll_answered = res_q.poll_answered;

`ifndef SYNTHESIS
	// an answered poll always leaves the engine waiting to reply
	assert property (@(posedge clk) disable iff (!arst_n)
		proc && answered_d |=> phase_q == PH_PENDING && res_q.poll_answered)
		else $error("answered poll did not enter reply pending");

	// the line is only driven while transmitting
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.line_drive == (res_q.phase == PH_TRANSMIT))
		else $error("line drive does not match transmit phase");

	// reception never counts past the eight data bits
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_RECEIVE |-> bit_idx_q <= BYTE_BITS)
		else $error("receive bit index out of range");

	// a held item stays put while the result side is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost its item under stall");
`endif

endmodule
